// ===== src/lla_pkg.sv =====
// ----------------------------------------------------------------------------
// lla_pkg
// Shared types and constants for the life-like automaton step block.
// ----------------------------------------------------------------------------
package lla_pkg;

  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 9;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_GRID_WIDTH   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_GRID_HEIGHT  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_BIRTH_MASK   = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_SURVIVE_MASK = 2'd3;

  // configuration reset values
  localparam logic [6:0] RST_GRID_WIDTH   = 7'd64;
  localparam logic [6:0] RST_GRID_HEIGHT  = 7'd64;
  localparam logic [8:0] RST_BIRTH_MASK   = 9'd8;
  localparam logic [8:0] RST_SURVIVE_MASK = 9'd12;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_ADVANCE = 2'd3
  } lla_cmd_t;

  typedef struct packed {
    lla_cmd_t   cmd;
    logic [5:0] x_coord;
    logic [5:0] y_coord;
    logic       alive_value;
  } lla_in_t;

  typedef struct packed {
    logic cell_alive;
    logic status;
  } lla_out_t;

endpackage

// ===== src/lla_ram.sv =====
// ----------------------------------------------------------------------------
// lla_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lla_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/life_like_automaton_step.sv =====
// ----------------------------------------------------------------------------
// life_like_automaton_step
// Toroidal life-like cellular automaton held in a row memory.
//
// One command per input transaction (write cell, read cell, clear all,
// advance one generation); every command returns exactly one result
// transaction carrying cell_alive and status. Commands run one at a time;
// in_stall is high while a command is in progress.
//   write / read cell : row read, row write-back, result
//   out-of-grid access: status 1, store untouched
//   clear all         : all MAX_HEIGHT rows, one row cleared per cycle
//   advance           : one row is updated per cycle, and the memory read
//                       port, one row a cycle, sets that pace
// After reset the store is swept clean with in_stall high;
// configuration writes are taken at any time. The result sits in an output
// register, so the next command is accepted while it waits; a command that
// finishes while that register is still stalled holds its result until the
// receiver takes the previous one.
// ----------------------------------------------------------------------------
module life_like_automaton_step
  import lla_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              in_valid,
  output logic              in_stall,
  input  lla_in_t           in_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output lla_out_t          out_data,
  // configuration port
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int RAW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int COL_AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CELL,
    S_ADV_UP,
    S_ADV_CUR,
    S_ADV_ROW,
    S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [6:0] grid_width_r;
  logic [6:0] grid_height_r;
  logic [8:0] birth_mask_r;
  logic [8:0] survive_mask_r;

  // command context
  lla_cmd_t        cmd_r;
  logic [5:0]      x_r;
  logic [RAW-1:0]  row_r;
  logic            val_r;
  logic            clr_cmd_r;
  logic [RAW-1:0]  clr_cnt_r;
  lla_out_t        res_r;
  logic            out_valid_r;
  lla_out_t        out_data_r;

  // generation window
  logic [MAX_WIDTH-1:0] up_r;
  logic [MAX_WIDTH-1:0] cur_r;
  logic [MAX_WIDTH-1:0] first_r;
  logic [RAW-1:0]       y_r;

  // memory ports
  logic                 ram_we;
  logic [RAW-1:0]       ram_waddr;
  logic [MAX_WIDTH-1:0] ram_wdata;
  logic [RAW-1:0]       ram_raddr;
  logic [MAX_WIDTH-1:0] ram_rdata;

  logic [6:0]           w_eff;
  logic [6:0]           h_eff;
  logic                 in_acc;
  logic                 coord_bad;
  logic                 last_row;
  logic [MAX_WIDTH-1:0] dn_row;
  logic [MAX_WIDTH-1:0] new_row;
  logic [MAX_WIDTH-1:0] cell_row;
  logic                 out_free;

  // Clamp the configured size: zero acts as one, above the maximum acts as it.
  always_comb begin
    if (grid_width_r == 7'd0) begin
      w_eff = 7'd1;
    end else if (32'(grid_width_r) > MAX_WIDTH) begin
      w_eff = 7'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_r;
    end
    if (grid_height_r == 7'd0) begin
      h_eff = 7'd1;
    end else if (32'(grid_height_r) > MAX_HEIGHT) begin
      h_eff = 7'(MAX_HEIGHT);
    end else begin
      h_eff = grid_height_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign coord_bad = ({1'b0, in_data.x_coord} >= w_eff) ||
                     ({1'b0, in_data.y_coord} >= h_eff);
  assign last_row  = (y_r == RAW'(h_eff - 7'd1));
  // below the last row the saved first row is used, else the old row comes from memory
  assign dn_row    = last_row ? first_r : ram_rdata;
  assign out_free  = !out_valid_r || !out_stall;

  // Next generation of the current row; columns outside the grid keep their value.
  always_comb begin
    int          li;
    int          ri;
    logic [3:0]  n;
    logic [8:0]  rule;
    for (int x = 0; x < MAX_WIDTH; x++) begin
      li = (x == 0) ? int'(w_eff) - 1 : x - 1;
      ri = (x + 1 >= int'(w_eff)) ? 0 : x + 1;
      n  = 4'(up_r[COL_AW'(li)])   + 4'(up_r[x])   + 4'(up_r[COL_AW'(ri)]) +
           4'(cur_r[COL_AW'(li)])                  + 4'(cur_r[COL_AW'(ri)]) +
           4'(dn_row[COL_AW'(li)]) + 4'(dn_row[x]) + 4'(dn_row[COL_AW'(ri)]);
      rule = cur_r[x] ? survive_mask_r : birth_mask_r;
      new_row[x] = (x < int'(w_eff)) ? rule[n] : cur_r[x];
    end
  end

  // Single-cell update of the row returned by the memory.
  always_comb begin
    cell_row = ram_rdata;
    cell_row[COL_AW'(x_r)] = val_r;
  end

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = y_r;
    ram_wdata = new_row;
    ram_raddr = RAW'(in_data.y_coord);
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_IDLE: begin
        // advance starts with the last row: the row above row zero
        if (in_data.cmd == CMD_ADVANCE) begin
          ram_raddr = RAW'(h_eff - 7'd1);
        end
      end
      S_CELL: begin
        ram_we    = (cmd_r == CMD_WRITE);
        ram_waddr = row_r;
        ram_wdata = cell_row;
      end
      S_ADV_UP: begin
        ram_raddr = '0;
      end
      S_ADV_CUR: begin
        ram_raddr = RAW'(1);
      end
      S_ADV_ROW: begin
        // write row y back while fetching row y+2
        ram_we    = 1'b1;
        ram_raddr = y_r + RAW'(2);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  lla_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT),
    .AW    (RAW)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_cnt_r      <= '0;
      clr_cmd_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      grid_width_r   <= RST_GRID_WIDTH;
      grid_height_r  <= RST_GRID_HEIGHT;
      birth_mask_r   <= RST_BIRTH_MASK;
      survive_mask_r <= RST_SURVIVE_MASK;
    end else begin
      // configuration writes land at once
      if (cfg_we) begin
        case (cfg_addr)
          CFG_GRID_WIDTH:   grid_width_r   <= cfg_wdata[6:0];
          CFG_GRID_HEIGHT:  grid_height_r  <= cfg_wdata[6:0];
          CFG_BIRTH_MASK:   birth_mask_r   <= cfg_wdata;
          CFG_SURVIVE_MASK: survive_mask_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // load a finished result, else drop the result once the receiver takes it
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLEAR: begin
          if (clr_cnt_r == RAW'(MAX_HEIGHT - 1)) begin
            clr_cnt_r <= '0;
            state_r   <= clr_cmd_r ? S_DONE : S_IDLE;
          end else begin
            clr_cnt_r <= clr_cnt_r + RAW'(1);
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_data.cmd;
            x_r   <= in_data.x_coord;
            row_r <= RAW'(in_data.y_coord);
            val_r <= in_data.alive_value;
            case (in_data.cmd)
              CMD_WRITE, CMD_READ: begin
                res_r <= '{cell_alive: 1'b0, status: coord_bad};
                if (coord_bad) begin
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_CELL;
                end
              end
              CMD_CLEAR: begin
                res_r     <= '0;
                clr_cmd_r <= 1'b1;
                state_r   <= S_CLEAR;
              end
              CMD_ADVANCE: begin
                res_r   <= '0;
                state_r <= S_ADV_UP;
              end
              default: begin
                res_r   <= '0;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_CELL: begin
          if (cmd_r == CMD_READ) begin
            res_r.cell_alive <= ram_rdata[COL_AW'(x_r)];
          end
          state_r <= S_DONE;
        end
        S_ADV_UP: begin
          up_r    <= ram_rdata;
          state_r <= S_ADV_CUR;
        end
        S_ADV_CUR: begin
          cur_r   <= ram_rdata;
          first_r <= ram_rdata;
          y_r     <= '0;
          state_r <= S_ADV_ROW;
        end
        S_ADV_ROW: begin
          // slide the window down one row
          up_r  <= cur_r;
          cur_r <= ram_rdata;
          y_r   <= y_r + RAW'(1);
          if (last_row) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (out_free) begin
            out_data_r  <= res_r;
            clr_cmd_r   <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== sim/life_like_automaton_step_tb.sv =====
// ----------------------------------------------------------------------------
// life_like_automaton_step_tb
// Self-checking bench for the toroidal life-like automaton step block.
//
// A predictor keeps its own copy of the cell store and the four registers.
// It works out the result of every accepted command, including a full
// generation step. A directed table covers reset contents, the grid
// corners, wrap-around, out-of-grid accesses, clamped grid sizes and every
// command. Random phases follow, each under its own register setting.
// Both sides idle and stall at random, with some phases running flat out.
// ----------------------------------------------------------------------------
module life_like_automaton_step_tb;
  import lla_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int          PHASES        = 8;
  localparam int          PHASE_ITEMS   = 72;

  localparam lla_out_t RES_DONE    = '{cell_alive: 1'b0, status: 1'b0};
  localparam lla_out_t RES_ALIVE   = '{cell_alive: 1'b1, status: 1'b0};
  localparam lla_out_t RES_OUTSIDE = '{cell_alive: 1'b0, status: 1'b1};

  // one row of the directed table: a register write or a command
  typedef struct {
    bit                is_cfg;
    logic [CFG_AW-1:0] reg_idx;
    logic [CFG_DW-1:0] reg_val;
    lla_in_t           item;
    bit                typed;
    lla_out_t          want;
  } plan_row_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  lla_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  lla_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [CFG_AW-1:0] cfg_addr  = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  // predictor state: cell store and register copies
  logic [63:0] life_board [64];
  logic [6:0]  width_reg;
  logic [6:0]  height_reg;
  logic [8:0]  birth_reg;
  logic [8:0]  survive_reg;

  lla_out_t    owed_results [$];
  plan_row_t   plan [$];
  int          mismatches   = 0;
  int          results_seen = 0;
  int unsigned cycle_count  = 0;
  bit          calm         = 1'b0;

  life_like_automaton_step uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Stop a hung run.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             owed_results.size());
    $display("FAILURE");
    $finish;
  end

  // Grid size as the block uses it: zero acts as one, above 64 acts as 64.
  function automatic int eff_size(logic [6:0] v);
    if (v == 7'd0) return 1;
    if (v > 7'd64) return 64;
    return int'(v);
  endfunction

  // Apply one command to the predicted store and return its result.
  function automatic lla_out_t step_automaton(lla_in_t c);
    lla_out_t    r;
    logic [63:0] old_gen [64];
    int          w;
    int          h;
    int          n;
    r = RES_DONE;
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    case (c.cmd)
      CMD_WRITE, CMD_READ: begin
        if (int'(c.x_coord) >= w || int'(c.y_coord) >= h) begin
          r.status = 1'b1;
        end else if (c.cmd == CMD_WRITE) begin
          life_board[c.y_coord][c.x_coord] = c.alive_value;
        end else begin
          r.cell_alive = life_board[c.y_coord][c.x_coord];
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < 64; i++) life_board[i] = '0;
      end
      default: begin
        // every cell of the grid in use reads the old generation; offsets
        // wrap one by one, so tiny grids count some cells more than once
        old_gen = life_board;
        for (int y = 0; y < h; y++) begin
          for (int x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dx = -1; dx <= 1; dx++) begin
                if (dy != 0 || dx != 0) n += old_gen[(y + dy + h) % h][(x + dx + w) % w];
              end
            end
            life_board[y][x] = old_gen[y][x] ? survive_reg[n] : birth_reg[n];
          end
        end
      end
    endcase
    return r;
  endfunction

  function automatic void add_cmd(lla_cmd_t c, int x, int y, bit v, bit typed,
                                  lla_out_t want);
    plan_row_t row;
    row = '{default: '0};
    row.item.cmd         = c;
    row.item.x_coord     = 6'(x);
    row.item.y_coord     = 6'(y);
    row.item.alive_value = v;
    row.typed            = typed;
    row.want             = want;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_AW-1:0] idx, int val);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = CFG_DW'(val);
    plan.push_back(row);
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("mismatch at result %0d: %s", results_seen, what);
  endtask

  // Offer one command after a random gap and hold it until accepted; the
  // expectation is queued at the accepting edge.
  task automatic send_command(input lla_in_t item, input bit typed, input lla_out_t want);
    int       gap;
    lla_out_t got;
    gap = calm ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      in_data  <= lla_in_t'($urandom);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    got = step_automaton(item);
    owed_results.push_back(typed ? want : got);
  endtask

  // Drop valid and hold until every outstanding result has come back.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_AW-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DW'(val);
    @(posedge clk);
    case (idx)
      CFG_GRID_WIDTH:  width_reg   = 7'(val);
      CFG_GRID_HEIGHT: height_reg  = 7'(val);
      CFG_BIRTH_MASK:  birth_reg   = 9'(val);
      default:         survive_reg = 9'(val);
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Result side: stall for a random number of cycles, then take one
  // transaction.
  initial begin : result_sink
    int hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    lla_out_t due;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        flag_mismatch("result arrived with nothing outstanding");
      end else begin
        due = owed_results.pop_front();
        if (out_data.cell_alive !== due.cell_alive)
          flag_mismatch($sformatf("cell_alive %b, expected %b", out_data.cell_alive,
                                  due.cell_alive));
        if (out_data.status !== due.status)
          flag_mismatch($sformatf("status %b, expected %b", out_data.status, due.status));
      end
    end
  end

  initial begin : stimulus
    lla_in_t item;
    int      w;
    int      h;
    int      pick;

    for (int i = 0; i < 64; i++) life_board[i] = '0;
    width_reg   = RST_GRID_WIDTH;
    height_reg  = RST_GRID_HEIGHT;
    birth_reg   = RST_BIRTH_MASK;
    survive_reg = RST_SURVIVE_MASK;

    // Directed table. Reset contents and corners on the full 64x64 grid,
    // then a blinker laid across the left/right wrap.
    add_cmd(CMD_READ,     0,  0, 1'b0, 1'b1, RES_DONE);
    add_cmd(CMD_READ,    63, 63, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_WRITE,   63, 63, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_READ,    63, 63, 1'b0, 1'b1, RES_ALIVE);
    add_cmd(CMD_WRITE,   63, 10, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_WRITE,    0, 10, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_WRITE,    1, 10, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_ADVANCE,  0,  0, 1'b0, 1'b1, RES_DONE);
    add_cmd(CMD_READ,     0,  9, 1'b0, 1'b0, RES_DONE);
    add_cmd(CMD_READ,     0, 11, 1'b0, 1'b0, RES_DONE);
    add_cmd(CMD_READ,    63, 10, 1'b0, 1'b0, RES_DONE);
    add_cmd(CMD_CLEAR,   63, 63, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_READ,    63, 63, 1'b0, 1'b1, RES_DONE);
    // width zero acts as one column, height above the maximum as 64 rows
    add_cfg(CFG_GRID_WIDTH, 0);
    add_cfg(CFG_GRID_HEIGHT, 127);
    add_cmd(CMD_WRITE,    1,  0, 1'b1, 1'b1, RES_OUTSIDE);
    add_cmd(CMD_READ,     0, 63, 1'b0, 1'b0, RES_DONE);
    add_cmd(CMD_WRITE,    0,  5, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_ADVANCE,  0,  0, 1'b0, 1'b1, RES_DONE);
    add_cmd(CMD_READ,     0,  5, 1'b0, 1'b0, RES_DONE);
    // two columns by one row with full birth and empty survive masks
    add_cfg(CFG_GRID_WIDTH, 2);
    add_cfg(CFG_GRID_HEIGHT, 1);
    add_cfg(CFG_BIRTH_MASK, 511);
    add_cfg(CFG_SURVIVE_MASK, 0);
    add_cmd(CMD_READ,     2,  0, 1'b0, 1'b1, RES_OUTSIDE);
    add_cmd(CMD_READ,     0,  1, 1'b0, 1'b1, RES_OUTSIDE);
    add_cmd(CMD_WRITE,    1,  0, 1'b1, 1'b1, RES_DONE);
    add_cmd(CMD_ADVANCE,  0,  0, 1'b0, 1'b1, RES_DONE);
    add_cmd(CMD_READ,     1,  0, 1'b0, 1'b0, RES_DONE);
    add_cmd(CMD_READ,     0,  0, 1'b0, 1'b0, RES_DONE);

    // Hold reset, then release it at a falling edge.
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; registers only change with nothing in flight.
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_idle();
        write_register(plan[i].reg_idx, int'(plan[i].reg_val));
      end else begin
        send_command(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      calm = (phase % 3 == 2);
      case (phase)
        0: begin
          write_register(CFG_GRID_WIDTH, 64);
          write_register(CFG_GRID_HEIGHT, 64);
          write_register(CFG_BIRTH_MASK, 8);
          write_register(CFG_SURVIVE_MASK, 12);
        end
        1: begin
          write_register(CFG_GRID_WIDTH, 0);
          write_register(CFG_GRID_HEIGHT, 0);
          write_register(CFG_BIRTH_MASK, 511);
          write_register(CFG_SURVIVE_MASK, 0);
        end
        2: begin
          write_register(CFG_GRID_WIDTH, 127);
          write_register(CFG_GRID_HEIGHT, 2);
          write_register(CFG_BIRTH_MASK, 0);
          write_register(CFG_SURVIVE_MASK, 511);
        end
        3: begin
          write_register(CFG_GRID_WIDTH, 1);
          write_register(CFG_GRID_HEIGHT, 127);
          write_register(CFG_BIRTH_MASK, int'($urandom_range(0, 511)));
          write_register(CFG_SURVIVE_MASK, int'($urandom_range(0, 511)));
        end
        default: begin
          // mostly small grids, so writes build up dense patterns
          write_register(CFG_GRID_WIDTH, int'(($urandom_range(0, 1) != 0) ?
                         $urandom_range(1, 10) : $urandom_range(0, 127)));
          write_register(CFG_GRID_HEIGHT, int'(($urandom_range(0, 1) != 0) ?
                         $urandom_range(1, 10) : $urandom_range(0, 127)));
          write_register(CFG_BIRTH_MASK, int'($urandom_range(0, 511)));
          write_register(CFG_SURVIVE_MASK, int'($urandom_range(0, 511)));
        end
      endcase

      w = eff_size(width_reg);
      h = eff_size(height_reg);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        item.cmd = (pick < 40) ? CMD_WRITE :
                   (pick < 76) ? CMD_READ :
                   (pick < 97) ? CMD_ADVANCE : CMD_CLEAR;
        // a quarter of the coordinates span the whole field range
        if ($urandom_range(0, 3) == 0) begin
          item.x_coord = 6'($urandom);
          item.y_coord = 6'($urandom);
        end else begin
          item.x_coord = 6'($urandom_range(0, w - 1));
          item.y_coord = 6'($urandom_range(0, h - 1));
        end
        item.alive_value = ($urandom_range(0, 9) < 7);
        send_command(item, 1'b0, RES_DONE);
      end
    end

    // Drain, then watch a while longer for stray results.
    wait_idle();
    repeat (DEF_MAX_HEIGHT + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== life_like_automaton_step.f =====
src/lla_pkg.sv
src/lla_ram.sv
src/life_like_automaton_step.sv
sim/life_like_automaton_step_tb.sv
